### design/assert_macros.svh
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition at one edge that must be followed by another at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/vcrm_pkg.sv
package vcrm_pkg;

   typedef enum logic [1:0] {
      KIND_WR_REQ     = 2'd0,
      KIND_WR_COMMIT  = 2'd1,
      KIND_RD_REQ     = 2'd2,
      KIND_RD_ADVANCE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_FULL_EMPTY = 2'd1,
      ST_MISUSE     = 2'd2
   } status_type;

   localparam int HDR_BYTES     = 8;
   localparam int HDR_W         = 15;
   localparam int SIZE_W        = 14;
   localparam int GAP_BIT       = 14;
   localparam int OFFSET_OUT_W  = 13;
   localparam int CFG_W         = 4;
   localparam int CFG_MIN_LOG2  = 6;
   localparam logic [CFG_W-1:0] CFG_RESET_LOG2 = 4'd13;

   // Header word writes issued by one request.
   typedef struct packed {
      logic             ram_we;
      logic [HDR_W-1:0] ram_word;
      logic             slot0_we;
      logic [HDR_W-1:0] slot0_word;
   } hdr_wr_type;

endpackage

### design/vcrm_ram.sv
module vcrm_ram import vcrm_pkg::*; #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/vcrm_hdr_store.sv
module vcrm_hdr_store import vcrm_pkg::*; #(
   parameter int SLOT_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  hdr_wr_type        wr,
   input  logic [SLOT_W-1:0] wr_slot,
   input  logic [SLOT_W-1:0] rd_slot_next,
   input  logic [SLOT_W-1:0] rd_slot,
   output logic [HDR_W-1:0]  rd_word,
   output logic [HDR_W-1:0]  slot0_word
);

   // The header at offset zero lives in a register so that a wrapping commit
   // needs only one memory write.
   logic [HDR_W-1:0] slot0_ff;
   logic             byp_ff;
   logic             byp_in;
   logic [HDR_W-1:0] byp_word_ff;
   logic [HDR_W-1:0] ram_q;

   vcrm_ram #(
      .WIDTH(HDR_W),
      .DEPTH(2 ** SLOT_W)
   ) u_ram (
      .clock(clock),
      .we   (wr.ram_we),
      .waddr(wr_slot),
      .wdata(wr.ram_word),
      .raddr(rd_slot_next),
      .rdata(ram_q)
   );

   assign byp_in = wr.ram_we && (wr_slot == rd_slot_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
      byp_word_ff <= wr.ram_word;
      if (wr.slot0_we) begin
         slot0_ff <= wr.slot0_word;
      end
   end

   always_comb begin
      if (rd_slot == '0) begin
         rd_word = slot0_ff;
      end else if (byp_ff) begin
         rd_word = byp_word_ff;
      end else begin
         rd_word = ram_q;
      end
   end

   assign slot0_word = slot0_ff;

endmodule

### design/variable_chunk_ring_manager_top.sv
// Pointer manager for a byte ring of variable-length records, each behind an
// 8-byte header. A request is taken at a rising edge with start high and busy
// low; req_kind selects write request, write commit, read request or read
// advance, and req_amount gives the bytes wanted or written.
// Every request gives exactly one response in the next cycle: rsp_strobe is
// high for that single cycle with rsp_status, rsp_payload_offset and
// rsp_length. The receiver cannot stall, so results are never held back.
// A new request may be taken in every cycle. The header word at the tail is
// read ahead from the header memory each cycle, with a bypass for a write to
// the same slot, so each request completes in one register-to-register pass.
// The csr port writes the ring size as a log2 value, clamped to the range
// from 64 bytes to RING_BYTES; a write also empties the ring and drops any
// reservation. It must be written only while no request is in flight; the
// block does not enforce this. Synchronous reset empties the ring and sets
// the size from log2 value 13; busy is high while reset is asserted and low
// otherwise. The header memory is not cleared; only written slots are read.
`include "assert_macros.svh"

module variable_chunk_ring_manager_top import vcrm_pkg::*; #(
   parameter int RING_BYTES = 8192
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_kind,
   input  logic [SIZE_W-1:0]       req_amount,
   output logic                    rsp_strobe,
   output logic [1:0]              rsp_status,
   output logic [OFFSET_OUT_W-1:0] rsp_payload_offset,
   output logic [SIZE_W-1:0]       rsp_length,
   input  logic                    csr_we,
   input  logic [CFG_W-1:0]        csr_wdata
);

   localparam int AW     = $clog2(RING_BYTES);
   localparam int SLOT_W = AW - 3;
   localparam int CW     = (AW + 2 > 16) ? AW + 2 : 16;

   function automatic logic [AW:0] ring_size(input logic [CFG_W-1:0] lg_raw);
      logic [4:0] lg_c;
      lg_c = 5'(lg_raw);
      if (lg_raw < CFG_W'(CFG_MIN_LOG2)) begin
         lg_c = 5'(CFG_MIN_LOG2);
      end
      if (int'(lg_raw) > AW) begin
         lg_c = 5'(AW);
      end
      return (AW + 1)'(1) << lg_c;
   endfunction

   function automatic logic [CW-1:0] pad8(input logic [CW-1:0] x);
      return (x + CW'(7)) & ~CW'(7);
   endfunction

   logic [AW-1:0]  head_ff, head_in, tail_ff, tail_in, mask_ff, mask_in;
   logic [AW:0]    size_ff, size_in, resv_ff, resv_in, gap_ff, gap_in;
   logic           rsp_strobe_ff;
   status_type     rsp_status_ff, rsp_status_in;
   logic [OFFSET_OUT_W-1:0] rsp_offset_ff;
   logic [SIZE_W-1:0]       rsp_length_ff;
   logic           accept;
   kind_type       kind;
   hdr_wr_type     hdr_wr;
   logic [HDR_W-1:0] hdr_t, hdr_0;
   logic [CW-1:0]  head_m, tail_m, size_c, mask_c, amount_c, pad_amt, need;
   logic [CW-1:0]  space_w, end_c, len1, len2, rspace, resv_c, gap_c;
   logic [CW-1:0]  rsp_offset_in, rsp_length_in, head_next, tail_next;
   logic           head_slot0;

   assign busy   = reset;
   assign accept = start && !busy;
   assign kind   = kind_type'(req_kind);

   assign head_m     = CW'(head_ff & mask_ff);
   assign tail_m     = CW'(tail_ff & mask_ff);
   assign size_c     = CW'(size_ff);
   assign mask_c     = CW'(mask_ff);
   assign resv_c     = CW'(resv_ff);
   assign gap_c      = CW'(gap_ff);
   assign amount_c   = CW'(req_amount);
   assign pad_amt    = pad8(amount_c);
   assign need       = CW'(2 * HDR_BYTES) + pad_amt;
   assign head_slot0 = (head_m[AW-1:3] == '0);

   always_comb begin
      if (head_m > tail_m) begin
         space_w = ((tail_m + size_c - head_m) & mask_c) - CW'(1);
         rspace  = head_m - tail_m;
      end else if (head_m < tail_m) begin
         space_w = tail_m - head_m - CW'(1);
         rspace  = (head_m + size_c - tail_m) & mask_c;
      end else begin
         space_w = size_c - CW'(1);
         rspace  = '0;
      end
   end

   assign end_c     = head_m + space_w;
   assign len1      = size_c - head_m;
   assign len2      = end_c & mask_c;
   assign head_next = (head_m + gap_c + CW'(HDR_BYTES) + pad_amt) & mask_c;
   assign tail_next = (tail_m + CW'(HDR_BYTES) + pad8(CW'(hdr_t[SIZE_W-1:0]))) & mask_c;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      resv_in       = resv_ff;
      gap_in        = gap_ff;
      size_in       = size_ff;
      mask_in       = mask_ff;
      hdr_wr        = '0;
      rsp_status_in = ST_OK;
      rsp_offset_in = '0;
      rsp_length_in = '0;
      if (accept) begin
         unique case (kind)
            KIND_WR_REQ: begin
               resv_in = '0;
               gap_in  = '0;
               if (end_c > size_c) begin
                  if (len1 < need) begin
                     if (len2 < need) begin
                        rsp_status_in = ST_FULL_EMPTY;
                     end else begin
                        resv_in       = len2[AW:0];
                        gap_in        = len1[AW:0];
                        rsp_offset_in = CW'(HDR_BYTES);
                        rsp_length_in = len2;
                     end
                  end else begin
                     resv_in       = len1[AW:0];
                     rsp_offset_in = head_m + CW'(HDR_BYTES);
                     rsp_length_in = len1;
                  end
               end else if (space_w < need) begin
                  rsp_status_in = ST_FULL_EMPTY;
               end else begin
                  resv_in       = space_w[AW:0];
                  rsp_offset_in = head_m + CW'(HDR_BYTES);
                  rsp_length_in = space_w;
               end
            end
            KIND_WR_COMMIT: begin
               if (resv_c == '0 || amount_c > resv_c) begin
                  rsp_status_in = ST_MISUSE;
               end else begin
                  if (gap_c != '0) begin
                     hdr_wr.ram_we   = !head_slot0;
                     hdr_wr.ram_word = {1'b1, SIZE_W'(gap_c - CW'(HDR_BYTES))};
                     hdr_wr.slot0_we = 1'b1;
                  end else begin
                     hdr_wr.ram_we   = !head_slot0;
                     hdr_wr.ram_word = HDR_W'(req_amount);
                     hdr_wr.slot0_we = head_slot0;
                  end
                  hdr_wr.slot0_word = HDR_W'(req_amount);
                  head_in = head_next[AW-1:0];
                  resv_in = '0;
                  gap_in  = '0;
               end
            end
            KIND_RD_REQ: begin
               if (rspace == '0) begin
                  rsp_status_in = ST_FULL_EMPTY;
               end else if ((tail_m + rspace > size_c) && hdr_t[GAP_BIT]) begin
                  tail_in       = '0;
                  rsp_offset_in = CW'(HDR_BYTES);
                  rsp_length_in = CW'(hdr_0[SIZE_W-1:0]);
               end else begin
                  rsp_offset_in = tail_m + CW'(HDR_BYTES);
                  rsp_length_in = CW'(hdr_t[SIZE_W-1:0]);
               end
            end
            KIND_RD_ADVANCE: begin
               if (head_m == tail_m) begin
                  rsp_status_in = ST_MISUSE;
               end else begin
                  tail_in = tail_next[AW-1:0];
               end
            end
         endcase
      end
      if (csr_we) begin
         size_in = ring_size(csr_wdata);
         mask_in = size_in[AW-1:0] - AW'(1);
         head_in = '0;
         tail_in = '0;
         resv_in = '0;
         gap_in  = '0;
      end
      if (reset) begin
         tail_in = '0;
      end
   end

   vcrm_hdr_store #(
      .SLOT_W(SLOT_W)
   ) u_hdr_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (hdr_wr),
      .wr_slot     (head_m[AW-1:3]),
      .rd_slot_next(tail_in[AW-1:3]),
      .rd_slot     (tail_ff[AW-1:3]),
      .rd_word     (hdr_t),
      .slot0_word  (hdr_0)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= ring_size(CFG_RESET_LOG2);
         mask_ff       <= AW'(ring_size(CFG_RESET_LOG2) - (AW + 1)'(1));
         head_ff       <= '0;
         tail_ff       <= '0;
         resv_ff       <= '0;
         gap_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         size_ff       <= size_in;
         mask_ff       <= mask_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         resv_ff       <= resv_in;
         gap_ff        <= gap_in;
         rsp_strobe_ff <= accept;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in[OFFSET_OUT_W-1:0];
      rsp_length_ff <= rsp_length_in[SIZE_W-1:0];
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_offset_ff;
   assign rsp_length         = rsp_length_ff;

   `ASSERT_NEXT(a_request_answered, clock, reset, (accept && !reset), (rsp_strobe), "Request gave no response")
   `ASSERT_ALWAYS(a_fail_fields_zero, clock, reset, (!rsp_strobe || rsp_status_ff == ST_OK || (rsp_payload_offset == '0 && rsp_length == '0)), "Failed request carries data")
   `ASSERT_ALWAYS(a_ptr_aligned, clock, reset, (head_ff[2:0] == 3'b000 && tail_ff[2:0] == 3'b000), "Ring pointer not header aligned")
   `ASSERT_ALWAYS(a_ptr_in_ring, clock, reset, ((AW + 1)'(head_ff) < size_ff && (AW + 1)'(tail_ff) < size_ff), "Ring pointer beyond ring size")

endmodule

### dv/variable_chunk_ring_manager_top_tb.sv
`timescale 1ns / 100ps

import vcrm_pkg::*;

typedef struct {
   status_type              status;
   logic [OFFSET_OUT_W-1:0] offset;
   logic [SIZE_W-1:0]       length;
} ring_response;

class ring_tracker;
   localparam int TOTAL_BYTES = 8192;
   localparam int SLOTS = TOTAL_BYTES / HDR_BYTES;

   logic [CFG_W-1:0]  size_log2;
   logic [12:0]       head;
   logic [12:0]       tail;
   logic [SIZE_W-1:0] reserved;
   logic [SIZE_W-1:0] gap;
   logic [HDR_W-1:0]  headers [SLOTS];
   bit                written [SLOTS];
   ring_response      awaited [$];
   int                errors;

   function new();
      size_log2 = CFG_RESET_LOG2;
      errors = 0;
      clear();
   endfunction

   function void clear();
      head = '0;
      tail = '0;
      reserved = '0;
      gap = '0;
   endfunction

   function void write_ring_size(logic [CFG_W-1:0] value);
      size_log2 = value;
      clear();
   endfunction

   function int unsigned ring_bytes();
      int lg;
      lg = int'(size_log2);
      if (lg < CFG_MIN_LOG2) lg = CFG_MIN_LOG2;
      if (lg > $clog2(TOTAL_BYTES)) lg = $clog2(TOTAL_BYTES);
      return 32'(1) << lg;
   endfunction

   function int unsigned round_up8(int unsigned x);
      return (x + 7) & ~32'(7);
   endfunction

   function void write_slot(int unsigned off, int unsigned value);
      headers[off >> 3] = HDR_W'(value);
      written[off >> 3] = 1'b1;
   endfunction

   // A read of a header slot that has never been written must not be requested.
   function bit can_issue(kind_type k);
      int unsigned size, mask, hd, tl, space;
      size = ring_bytes();
      mask = size - 1;
      hd = 32'(head) & mask;
      tl = 32'(tail) & mask;
      if (k == KIND_WR_REQ || k == KIND_WR_COMMIT || hd == tl) return 1'b1;
      if (!written[tl >> 3]) return 1'b0;
      if (k == KIND_RD_REQ) begin
         space = (hd > tl) ? hd - tl : ((hd + size - tl) & mask);
         if (tl + space > size && headers[tl >> 3][GAP_BIT] && !written[0]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function void note_request(kind_type k, logic [SIZE_W-1:0] amt);
      int unsigned size, mask, hd, tl, a, need, space, top, len1, len2, h;
      ring_response r;
      size = ring_bytes();
      mask = size - 1;
      hd = 32'(head) & mask;
      tl = 32'(tail) & mask;
      a = 32'(amt);
      r.status = ST_OK;
      r.offset = '0;
      r.length = '0;
      case (k)
         KIND_WR_REQ: begin
            need = 2 * HDR_BYTES + round_up8(a);
            if (hd > tl) space = ((tl + size - hd) & mask) - 1;
            else if (hd < tl) space = tl - hd - 1;
            else space = size - 1;
            top = hd + space;
            reserved = '0;
            gap = '0;
            if (top > size) begin
               len1 = size - hd;
               if (len1 >= need) begin
                  reserved = SIZE_W'(len1);
                  r.offset = OFFSET_OUT_W'(hd + HDR_BYTES);
                  r.length = SIZE_W'(len1);
               end else begin
                  len2 = top & mask;
                  if (len2 < need) begin
                     r.status = ST_FULL_EMPTY;
                  end else begin
                     reserved = SIZE_W'(len2);
                     gap = SIZE_W'(len1);
                     r.offset = OFFSET_OUT_W'(HDR_BYTES);
                     r.length = SIZE_W'(len2);
                  end
               end
            end else if (space < need) begin
               r.status = ST_FULL_EMPTY;
            end else begin
               reserved = SIZE_W'(space);
               r.offset = OFFSET_OUT_W'(hd + HDR_BYTES);
               r.length = SIZE_W'(space);
            end
         end
         KIND_WR_COMMIT: begin
            if (reserved == 0 || a > 32'(reserved)) begin
               r.status = ST_MISUSE;
            end else begin
               if (gap != 0) begin
                  write_slot(hd, (32'(1) << GAP_BIT) | ((32'(gap) - HDR_BYTES) & 32'h3fff));
                  write_slot(0, a);
               end else begin
                  write_slot(hd, a);
               end
               head = 13'((hd + 32'(gap) + HDR_BYTES + round_up8(a)) & mask);
               reserved = '0;
               gap = '0;
            end
         end
         KIND_RD_REQ: begin
            space = (hd > tl) ? hd - tl : ((hd + size - tl) & mask);
            if (space == 0) begin
               r.status = ST_FULL_EMPTY;
            end else begin
               h = 32'(headers[tl >> 3]);
               if (tl + space > size && h[GAP_BIT]) begin
                  tail = '0;
                  h = 32'(headers[0]);
                  r.offset = OFFSET_OUT_W'(HDR_BYTES);
               end else begin
                  r.offset = OFFSET_OUT_W'(tl + HDR_BYTES);
               end
               r.length = SIZE_W'(h);
            end
         end
         default: begin
            if (hd == tl) begin
               r.status = ST_MISUSE;
            end else begin
               h = 32'(headers[tl >> 3]) & 32'h3fff;
               tail = 13'((tl + HDR_BYTES + round_up8(h)) & mask);
            end
         end
      endcase
      awaited.push_back(r);
   endfunction

   task report(string what);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   task check_response(logic [1:0] st, logic [OFFSET_OUT_W-1:0] off, logic [SIZE_W-1:0] len);
      ring_response e;
      if (awaited.size() == 0) begin
         report("response with no request outstanding");
      end else begin
         e = awaited.pop_front();
         if (st !== e.status)
            report($sformatf("status %0d, expected %0d", st, e.status));
         if (off !== e.offset)
            report($sformatf("payload offset %0d, expected %0d", off, e.offset));
         if (len !== e.length)
            report($sformatf("length %0d, expected %0d", len, e.length));
      end
   endtask
endclass

module variable_chunk_ring_manager_top_tb;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 1750;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_kind = KIND_WR_REQ;
   logic [SIZE_W-1:0]       req_amount = '0;
   logic                    rsp_strobe;
   logic [1:0]              rsp_status;
   logic [OFFSET_OUT_W-1:0] rsp_payload_offset;
   logic [SIZE_W-1:0]       rsp_length;
   logic                    csr_we = 1'b0;
   logic [CFG_W-1:0]        csr_wdata = '0;

   ring_tracker ring;
   int          items_sent = 0;
   bit          steady = 1'b0;

   variable_chunk_ring_manager_top #(.RING_BYTES(8192)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_amount(req_amount),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_payload_offset(rsp_payload_offset),
      .rsp_length(rsp_length),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         ring.check_response(rsp_status, rsp_payload_offset, rsp_length);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   function int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic pause(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
         req_kind <= 2'($urandom);
         req_amount <= SIZE_W'($urandom);
      end
   endtask

   task automatic issue(kind_type k, int unsigned amt);
      if (!steady) pause(gap_length());
      @(negedge clock);
      start <= 1'b1;
      req_kind <= k;
      req_amount <= SIZE_W'(amt);
      @(posedge clock);
      while (busy) @(posedge clock);
      ring.note_request(k, SIZE_W'(amt));
      items_sent++;
   endtask

   task automatic set_ring_size(int unsigned lg);
      @(negedge clock);
      start <= 1'b0;
      while (ring.awaited.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= CFG_W'(lg);
      @(posedge clock);
      ring.write_ring_size(CFG_W'(lg));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function int unsigned pick_amount();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 16383);
      return $urandom_range(0, ring.ring_bytes() / 2);
   endfunction

   function int unsigned pick_log2();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 6) return $urandom_range(6, 9);
      if (r < 8) return $urandom_range(10, 13);
      return $urandom_range(0, 15);
   endfunction

   // Mostly a reserve-then-commit pair or a read-then-advance pair, with some noise.
   task automatic random_step();
      int unsigned r, want, got;
      kind_type    k;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         want = pick_amount();
         issue(KIND_WR_REQ, want);
         if (ring.reserved != 0 && $urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 6) != 0) got = $urandom_range(0, want);
            else got = $urandom_range(0, 32'(ring.reserved) + 16);
            issue(KIND_WR_COMMIT, got);
         end
      end else if (r < 85) begin
         if (ring.can_issue(KIND_RD_REQ)) issue(KIND_RD_REQ, $urandom_range(0, 16383));
         if ($urandom_range(0, 7) != 0 && ring.can_issue(KIND_RD_ADVANCE))
            issue(KIND_RD_ADVANCE, $urandom_range(0, 16383));
      end else begin
         k = kind_type'($urandom_range(0, 3));
         if (ring.can_issue(k)) issue(k, $urandom_range(0, 16383));
      end
   endtask

   initial begin
      int target, phase_end, phase;
      ring = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty ring, misuse and full ring at the largest size.
      issue(KIND_RD_REQ, 0);
      issue(KIND_RD_ADVANCE, 0);
      issue(KIND_WR_COMMIT, 8);
      issue(KIND_WR_REQ, 0);
      issue(KIND_WR_COMMIT, 0);
      issue(KIND_RD_REQ, 0);
      issue(KIND_RD_ADVANCE, 0);
      issue(KIND_WR_REQ, 8192);
      issue(KIND_WR_COMMIT, 0);
      issue(KIND_WR_REQ, 16383);

      // Smallest ring: a commit above the reservation, then a request that wraps behind a gap.
      set_ring_size(6);
      issue(KIND_WR_REQ, 0);
      issue(KIND_WR_COMMIT, 16383);
      issue(KIND_WR_REQ, 20);
      issue(KIND_WR_COMMIT, 20);
      issue(KIND_RD_REQ, 0);
      issue(KIND_RD_ADVANCE, 0);
      issue(KIND_WR_REQ, 16);
      issue(KIND_WR_COMMIT, 16);
      issue(KIND_RD_REQ, 0);
      issue(KIND_RD_ADVANCE, 0);
      issue(KIND_WR_REQ, 16);
      issue(KIND_WR_COMMIT, 16);
      issue(KIND_RD_REQ, 0);
      issue(KIND_RD_ADVANCE, 0);

      target = items_sent + RANDOM_ITEMS;
      phase = 0;
      while (items_sent < target) begin
         case (phase)
            0: set_ring_size(15);
            1: set_ring_size(0);
            2: set_ring_size(13);
            default: set_ring_size(pick_log2());
         endcase
         steady = ($urandom_range(0, 3) == 0);
         phase_end = items_sent + $urandom_range(100, 250);
         while (items_sent < phase_end && items_sent < target) random_step();
         phase++;
      end

      @(negedge clock);
      start <= 1'b0;
      while (ring.awaited.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (ring.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule

### variable_chunk_ring_manager_top.f
+incdir+design
design/vcrm_pkg.sv
design/vcrm_ram.sv
design/vcrm_hdr_store.sv
design/variable_chunk_ring_manager_top.sv
dv/variable_chunk_ring_manager_top_tb.sv
